// ===== src/kss_pkg.sv =====
// kss_pkg: shared types, constants and the saturating add for the keyed sum table.
// Depends on nothing; imported by every module of the block.
`default_nettype none

package kss_pkg;

    localparam int KEY_W         = 32;
    localparam int VAL_W         = 32;
    localparam int SUM_W         = 48;
    localparam int TABLE_ENTRIES = 64;

    // One input record beat
    typedef struct packed {
        logic signed [KEY_W-1:0] record_key;
        logic signed [VAL_W-1:0] record_value;
        logic                    last_record;
    } rec_t;

    // One result entry beat
    typedef struct packed {
        logic signed [KEY_W-1:0] entry_key;
        logic signed [SUM_W-1:0] entry_sum;
        logic                    last_entry;
        logic                    overflow;
    } ent_t;

    // Per-cycle command broadcast to every cell
    typedef struct packed {
        logic absorb;   // a record is accepted this cycle
        logic insert;   // the record opens a new entry
        logic pop;      // dump: each cell takes its right neighbor
    } cell_cmd_t;

    typedef enum logic {
        ST_IDLE,
        ST_DUMP
    } state_t;

    // Add a sign-extended value to a sum, clamped to the sum range
    function automatic logic signed [SUM_W-1:0] sat_add(
        input logic signed [SUM_W-1:0] a,
        input logic signed [VAL_W-1:0] b
    );
        logic signed [SUM_W:0] s;
        logic signed [SUM_W-1:0] res;
        s = {a[SUM_W-1], a} + {{(SUM_W+1-VAL_W){b[VAL_W-1]}}, b};
        if (s[SUM_W] != s[SUM_W-1])
        begin
            res = s[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
        end
        else
        begin
            res = s[SUM_W-1:0];
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ===== src/kss_cell.sv =====
// kss_cell: one slot of the sorted table; holds a key and its running sum.
// Depends on kss_pkg. Chained left to right inside keyed_sum_sorted_table.
`default_nettype none

module kss_cell
    import kss_pkg::*;
(
    input  wire logic                    clk,
    input  wire cell_cmd_t               cmd,
    input  wire logic                    occupied,
    input  wire logic signed [KEY_W-1:0] rec_key,
    input  wire logic signed [VAL_W-1:0] rec_value,
    input  wire logic                    left_lt,
    input  wire logic signed [KEY_W-1:0] left_key,
    input  wire logic signed [SUM_W-1:0] left_sum,
    input  wire logic signed [KEY_W-1:0] right_key,
    input  wire logic signed [SUM_W-1:0] right_sum,
    output logic                         lt,
    output logic                         eq,
    output logic signed [KEY_W-1:0]      key,
    output logic signed [SUM_W-1:0]      sum
);

    logic signed [KEY_W-1:0] key_reg;
    logic signed [SUM_W-1:0] sum_reg;
    logic signed [KEY_W-1:0] key_next;
    logic signed [SUM_W-1:0] sum_next;

    // Compare the broadcast key against the held one
    assign lt  = occupied && (key_reg < rec_key);
    assign eq  = occupied && (key_reg == rec_key);
    assign key = key_reg;
    assign sum = sum_reg;

    // Accumulate, insert, shift right on insert, shift left on dump
    always_comb
    begin
        key_next = key_reg;
        sum_next = sum_reg;
        if (cmd.pop)
        begin
            key_next = right_key;
            sum_next = right_sum;
        end
        else if (cmd.absorb)
        begin
            if (eq)
            begin
                sum_next = sat_add(sum_reg, rec_value);
            end
            else if (cmd.insert && !lt)
            begin
                if (left_lt)
                begin
                    key_next = rec_key;
                    sum_next = sat_add('0, rec_value);
                end
                else
                begin
                    key_next = left_key;
                    sum_next = left_sum;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        sum_reg <= sum_next;
    end

endmodule

`default_nettype wire

// ===== src/keyed_sum_sorted_table.sv =====
// A record updates the table at the edge it is accepted; one per cycle unless stalled.
// A last record starts the dump on the next cycle: one entry per cycle from the output
// register while ent_stall is low; rec_stall stays high until the last entry is loaded.
// The dump shifts the cell chain left at each pop, with cell 0 feeding the output register.
// Reset clears the entry count, the overflow flag, the state and the output valid;
// the cell contents are never read before they are written and need no clearing.
`default_nettype none

module keyed_sum_sorted_table
    import kss_pkg::*;
#(
    parameter int ENTRIES = TABLE_ENTRIES
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic rec_valid,
    output logic      rec_stall,
    input  wire rec_t rec,
    output logic      ent_valid,
    input  wire logic ent_stall,
    output ent_t      ent
);

    localparam int          CNT_W   = $clog2(ENTRIES + 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(ENTRIES);
    localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             dropped_reg, dropped_next;
    logic             out_valid_reg, out_valid_next;
    ent_t             out_reg, out_next;

    logic                    accept;
    logic                    any_eq;
    logic                    full;
    logic                    pop;
    cell_cmd_t               cmd;
    logic [ENTRIES-1:0]      occ;
    logic [ENTRIES-1:0]      lt_vec;
    logic [ENTRIES-1:0]      eq_vec;
    logic signed [KEY_W-1:0] key_arr [ENTRIES];
    logic signed [SUM_W-1:0] sum_arr [ENTRIES];

    // Handshake and table status
    assign rec_stall = (state_reg == ST_DUMP);
    assign accept    = rec_valid && !rec_stall;
    assign any_eq    = |eq_vec;
    assign full      = (count_reg == CNT_FULL);
    assign pop       = (state_reg == ST_DUMP) && (!out_valid_reg || !ent_stall);

    assign cmd.absorb = accept;
    assign cmd.insert = !any_eq && !full;
    assign cmd.pop    = pop;

    // Cell chain
    for (genvar i = 0; i < ENTRIES; i++)
    begin : g_cell
        logic                    l_lt;
        logic signed [KEY_W-1:0] l_key;
        logic signed [SUM_W-1:0] l_sum;
        logic signed [KEY_W-1:0] r_key;
        logic signed [SUM_W-1:0] r_sum;

        assign occ[i] = (count_reg > CNT_W'(i));

        if (i == 0)
        begin : g_head
            assign l_lt  = 1'b1;
            assign l_key = rec.record_key;
            assign l_sum = '0;
        end
        else
        begin : g_body
            assign l_lt  = lt_vec[i-1];
            assign l_key = key_arr[i-1];
            assign l_sum = sum_arr[i-1];
        end

        if (i == ENTRIES - 1)
        begin : g_tail
            assign r_key = key_arr[i];
            assign r_sum = sum_arr[i];
        end
        else
        begin : g_mid
            assign r_key = key_arr[i+1];
            assign r_sum = sum_arr[i+1];
        end

        kss_cell u_cell (
            .clk       (clk),
            .cmd       (cmd),
            .occupied  (occ[i]),
            .rec_key   (rec.record_key),
            .rec_value (rec.record_value),
            .left_lt   (l_lt),
            .left_key  (l_key),
            .left_sum  (l_sum),
            .right_key (r_key),
            .right_sum (r_sum),
            .lt        (lt_vec[i]),
            .eq        (eq_vec[i]),
            .key       (key_arr[i]),
            .sum       (sum_arr[i])
        );
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && rec.last_record)
                begin
                    state_next = ST_DUMP;
                end
            end
            ST_DUMP:
            begin
                if (pop && (count_reg == CNT_ONE))
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Count, overflow flag and output register
    always_comb
    begin
        count_next     = count_reg;
        dropped_next   = dropped_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;

        if (accept && !any_eq)
        begin
            if (full)
            begin
                dropped_next = 1'b1;
            end
            else
            begin
                count_next = count_reg + CNT_ONE;
            end
        end

        if (pop)
        begin
            out_valid_next      = 1'b1;
            out_next.entry_key  = key_arr[0];
            out_next.entry_sum  = sum_arr[0];
            out_next.last_entry = (count_reg == CNT_ONE);
            out_next.overflow   = dropped_reg;
            count_next          = count_reg - CNT_ONE;
            if (count_reg == CNT_ONE)
            begin
                dropped_next = 1'b0;
            end
        end
        else if (!ent_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            dropped_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            dropped_reg   <= dropped_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign ent_valid = out_valid_reg;
    assign ent       = out_reg;

endmodule

`default_nettype wire

// ===== src/kss_checker.sv =====
// kss_checker: port-level assertions for keyed_sum_sorted_table, bound to the top level.
// Depends on kss_pkg.
`default_nettype none

module kss_checker
    import kss_pkg::*;
(
    input wire logic clk,
    input wire logic rst_n,
    input wire logic rec_valid,
    input wire logic rec_stall,
    input wire rec_t rec,
    input wire logic ent_valid,
    input wire logic ent_stall,
    input wire ent_t ent
);

    // A held result beat keeps its payload
    a_ent_hold: assert property (@(posedge clk) disable iff (!rst_n)
        ent_valid && ent_stall |=> ent_valid && $stable(ent))
        else $error("result beat changed while stalled");

    // A last record starts the dump, which blocks new records
    a_dump_starts: assert property (@(posedge clk) disable iff (!rst_n)
        rec_valid && !rec_stall && rec.last_record |=> rec_stall)
        else $error("dump did not start after last record");

    // Entries other than the final one only appear during a dump
    a_mid_dump: assert property (@(posedge clk) disable iff (!rst_n)
        ent_valid && !ent.last_entry |-> rec_stall)
        else $error("non-final entry outside dump");

    // Nothing follows the final entry of a dump unless a new dump is already running
    a_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        ent_valid && !ent_stall && ent.last_entry && !rec_stall |=> !ent_valid)
        else $error("entry emitted after final entry");

    // Overflow flag is the same on consecutive entries of one dump
    a_ovf_const: assert property (@(posedge clk) disable iff (!rst_n)
        ent_valid && !ent_stall && !ent.last_entry ##1 ent_valid
            |-> ent.overflow == $past(ent.overflow))
        else $error("overflow flag changed within a dump");

endmodule

bind keyed_sum_sorted_table kss_checker u_kss_checker (.*);

`default_nettype wire
